@@ rtl/i2ckd_pkg.sv @@
// ----------------------------------------------------------------------------
// i2ckd_pkg
// Types and constants shared by the I2C key and digit panel target.
// ----------------------------------------------------------------------------
package i2ckd_pkg;

  // 7-bit bus addresses
  localparam logic [6:0] KEY_ADDR  = 7'h24;
  localparam logic [6:0] DIG_FIRST = 7'h34;
  localparam logic [6:0] DIG_LAST  = 7'h37;

  // event kinds
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_STOP  = 2'd1;
  localparam logic [1:0] EV_RISE  = 2'd2;
  localparam logic [1:0] EV_FALL  = 2'd3;

  // configuration register byte addresses
  localparam logic [2:0] REG_KEY_RESPONSE = 3'd0;

  // bus phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RXADDR = 3'd1,
    PH_RXDATA = 3'd2,
    PH_TXDATA = 3'd3,
    PH_TXACK  = 3'd4,
    PH_IGNORE = 3'd5
  } phase_t;

  // one result item, sda_pull_low in the lowest bit
  typedef struct packed {
    logic       key_send_active;
    logic       key_read_done;
    logic [7:0] digit_segments;
    logic [6:0] digit_address;
    logic       digit_valid;
    logic       sda_pull_low;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_TDATA_W = 24;

  function automatic logic is_digit(input logic [6:0] a);
    return (a >= DIG_FIRST) && (a <= DIG_LAST);
  endfunction

endpackage

@@ rtl/i2c_target_key_and_digit_panel.sv @@
// ----------------------------------------------------------------------------
// i2c_target_key_and_digit_panel
// Event-driven I2C target: key address read and digit address writes.
// ----------------------------------------------------------------------------
// output: registered; a result is valid in the cycle after its event is accepted
// throughput: one item per cycle; the output register is refilled in the
//   cycle it is taken, so input only stalls while a result waits unread
// reset: rst (synchronous) clears bus state, key_response and the output
//   valid; no clearing pass, items are taken in the first cycle after
module i2c_target_key_and_digit_panel (
  input  logic        clk,
  input  logic        rst,
  // event items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] sda_level
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] sda_pull_low, [1] digit_valid,
                                 // [8:2] digit_address, [16:9] digit_segments,
                                 // [17] key_read_done, [18] key_send_active
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2ckd_pkg::*;

  logic       accept;
  logic [7:0] key_response;
  result_t    result;
  result_t    out_item;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2ckd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key_response (key_response)
  );

  i2ckd_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (s_tuser),
    .sda_level    (s_tdata[0]),
    .key_response (key_response),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_item};

endmodule

@@ rtl/i2ckd_regs.sv @@
// ----------------------------------------------------------------------------
// i2ckd_regs
// APB register block holding the key response byte.
// ----------------------------------------------------------------------------
module i2ckd_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  key_response
);
  import i2ckd_pkg::*;

  logic hit;

  // word decode, byte lanes ignored
  assign hit    = (paddr[2] == REG_KEY_RESPONSE[2]);
  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      key_response <= 8'd0;
    end else if (psel && penable && pwrite && pready && hit) begin
      key_response <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (hit) begin
      prdata = {24'd0, key_response};
    end
  end

endmodule

@@ rtl/i2ckd_fsm.sv @@
// ----------------------------------------------------------------------------
// i2ckd_fsm
// Bus protocol state machine: updates transaction state on each accepted
// event and forms that event's result.
// ----------------------------------------------------------------------------
module i2ckd_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic                sda_level,
  input  logic [7:0]          key_response,
  output i2ckd_pkg::result_t  result
);
  import i2ckd_pkg::*;

  phase_t     bus_phase, bus_phase_next;
  logic [3:0] bit_counter, bit_counter_next;
  logic [7:0] shift_in_byte, shift_in_byte_next;
  logic [6:0] matched_address, matched_address_next;
  logic       sda_drive, sda_drive_next;
  logic       digit_pending, digit_pending_next;
  logic [7:0] pending_segments, pending_segments_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase        <= PH_IDLE;
      bit_counter      <= 4'd0;
      shift_in_byte    <= 8'd0;
      matched_address  <= 7'd0;
      sda_drive        <= 1'b0;
      digit_pending    <= 1'b0;
      pending_segments <= 8'd0;
    end else if (accept) begin
      bus_phase        <= bus_phase_next;
      bit_counter      <= bit_counter_next;
      shift_in_byte    <= shift_in_byte_next;
      matched_address  <= matched_address_next;
      sda_drive        <= sda_drive_next;
      digit_pending    <= digit_pending_next;
      pending_segments <= pending_segments_next;
    end
  end

  // next state and result
  always_comb begin
    logic [6:0] addr;
    logic       rd;
    logic       ok;
    addr = shift_in_byte[7:1];
    rd   = shift_in_byte[0];
    ok   = (addr == KEY_ADDR) || (!rd && is_digit(addr));

    bus_phase_next        = bus_phase;
    bit_counter_next      = bit_counter;
    shift_in_byte_next    = shift_in_byte;
    matched_address_next  = matched_address;
    sda_drive_next        = sda_drive;
    digit_pending_next    = digit_pending;
    pending_segments_next = pending_segments;
    result                = '0;

    case (opcode)
      EV_START, EV_STOP: begin
        bus_phase_next        = (opcode == EV_START) ? PH_RXADDR : PH_IDLE;
        bit_counter_next      = 4'd0;
        shift_in_byte_next    = 8'd0;
        matched_address_next  = 7'd0;
        sda_drive_next        = 1'b0;
        digit_pending_next    = 1'b0;
        pending_segments_next = 8'd0;
      end
      EV_RISE: begin
        case (bus_phase)
          PH_RXADDR, PH_RXDATA: begin
            if (bit_counter < 4'd8) begin
              shift_in_byte_next = {shift_in_byte[6:0], sda_level};
              bit_counter_next   = bit_counter + 4'd1;
            end else if (bit_counter == 4'd8) begin
              bit_counter_next = 4'd9;
            end
          end
          PH_TXDATA: begin
            if (bit_counter < 4'd8) begin
              bit_counter_next = bit_counter + 4'd1;
            end
          end
          PH_TXACK: begin
            bit_counter_next = 4'd1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        // scl falling
        case (bus_phase)
          PH_RXADDR: begin
            if (bit_counter == 4'd8) begin
              matched_address_next = addr;
              sda_drive_next       = ok;
              if (!ok) begin
                bus_phase_next = PH_IGNORE;
              end
            end else if (bit_counter == 4'd9) begin
              bit_counter_next = 4'd0;
              if (matched_address == KEY_ADDR && rd) begin
                bus_phase_next = PH_TXDATA;
                sda_drive_next = !key_response[7];
              end else begin
                bus_phase_next     = PH_RXDATA;
                sda_drive_next     = 1'b0;
                shift_in_byte_next = 8'd0;
              end
            end
          end
          PH_RXDATA: begin
            if (bit_counter == 4'd8) begin
              sda_drive_next = 1'b1;
              if (is_digit(matched_address)) begin
                digit_pending_next    = 1'b1;
                pending_segments_next = shift_in_byte;
              end
            end else if (bit_counter == 4'd9) begin
              sda_drive_next = 1'b0;
              if (digit_pending) begin
                result.digit_valid    = 1'b1;
                result.digit_address  = matched_address;
                result.digit_segments = pending_segments;
              end
              digit_pending_next = 1'b0;
              bit_counter_next   = 4'd0;
              shift_in_byte_next = 8'd0;
            end
          end
          PH_TXDATA: begin
            if (bit_counter < 4'd8) begin
              // msb first
              sda_drive_next = !key_response[3'd7 - bit_counter[2:0]];
            end else begin
              sda_drive_next   = 1'b0;
              bus_phase_next   = PH_TXACK;
              bit_counter_next = 4'd0;
            end
          end
          PH_TXACK: begin
            if (bit_counter == 4'd1) begin
              result.key_read_done = 1'b1;
              sda_drive_next       = 1'b0;
              bus_phase_next       = PH_IGNORE;
              bit_counter_next     = 4'd0;
            end
          end
          PH_IGNORE: begin
            sda_drive_next = 1'b0;
          end
          default: begin
          end
        endcase
      end
    endcase

    result.sda_pull_low    = sda_drive_next;
    result.key_send_active = (bus_phase_next == PH_TXDATA) ||
                             (bus_phase_next == PH_TXACK);
  end

endmodule

@@ rtl/i2ckd_checker.sv @@
// ----------------------------------------------------------------------------
// i2ckd_checker
// Port-level checks on the result stream of the panel target.
// ----------------------------------------------------------------------------
module i2ckd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import i2ckd_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata[RESULT_W-1:0]);

  // a waiting result item is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item dropped or changed while stalled");

  // digit fields are zero unless a digit write is reported
  a_digit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.digit_valid |-> r.digit_address == 7'd0 &&
      r.digit_segments == 8'd0)
    else $error("digit fields set without digit_valid");

  // only digit addresses are reported, with the bus released
  a_digit_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.digit_valid |-> r.digit_address >= DIG_FIRST &&
      r.digit_address <= DIG_LAST && !r.sda_pull_low && !r.key_send_active)
    else $error("digit report outside the digit range");

  // a finished key read leaves transmit and releases SDA
  a_key_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.key_read_done |-> !r.key_send_active && !r.sda_pull_low &&
      !r.digit_valid)
    else $error("key read done while still sending");

endmodule

bind i2c_target_key_and_digit_panel i2ckd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
